// File: hw/rtl/rlefs_pkg.sv
package rlefs_pkg;

  localparam int CMD_W  = 2;
  localparam int PIX_W  = 8;
  localparam int IDX_W  = 12;
  localparam int FC_W   = 13;
  localparam int STS_W  = 2;
  localparam int VIS_W  = 13;
  localparam int TOT_W  = 17;

  localparam logic [FC_W-1:0] FRAME_COLS_RESET = 13'd640;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } lk_req_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [PIX_W-1:0] value;
    logic [VIS_W-1:0] visited;
  } lk_rsp_t;

endpackage

// File: hw/rtl/rlefs_cmd_if.sv
interface rlefs_cmd_if import rlefs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [PIX_W-1:0] pixel_value;
  logic [IDX_W-1:0] lookup_row;
  logic [IDX_W-1:0] lookup_col;

  modport source (output valid, output command, output pixel_value,
                  output lookup_row, output lookup_col, input ready);
  modport sink (input valid, input command, input pixel_value,
                input lookup_row, input lookup_col, output ready);
endinterface

// File: hw/rtl/rlefs_res_if.sv
interface rlefs_res_if import rlefs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [PIX_W-1:0] read_value;
  logic [VIS_W-1:0] runs_visited;
  logic [TOT_W-1:0] total_runs;

  modport source (output valid, output status, output read_value,
                  output runs_visited, output total_runs, input ready);
  modport sink (input valid, input status, input read_value,
                input runs_visited, input total_runs, output ready);
endinterface

// File: hw/rtl/rlefs_ram.sv
module rlefs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/rlefs_walk.sv
module rlefs_walk import rlefs_pkg::*; #(
  parameter int MAX_RUNS = 65536,
  parameter int MAX_ROWS = 4096,
  parameter int MAX_COLS = 4096
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  lk_req_t                                      req,
  input  logic [$clog2(MAX_ROWS+1)-1:0]                rows_done,
  input  logic                                         row_open,
  input  logic [$clog2(MAX_RUNS+1)-1:0]                runs_done,
  output logic                                         rfr_re,
  output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] rfr_raddr,
  input  logic [$clog2(MAX_RUNS+1)-1:0]                rfr_rdata,
  output logic                                         rs_re,
  output logic [$clog2(MAX_RUNS)-1:0]                  rs_raddr,
  input  logic [$clog2(MAX_COLS+1)+PIX_W-1:0]          rs_rdata,
  output lk_rsp_t                                      rsp
);

  localparam int RD_W  = $clog2(MAX_ROWS+1);
  localparam int RA_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RN_W  = $clog2(MAX_RUNS+1);
  localparam int RS_AW = $clog2(MAX_RUNS);
  localparam int CNT_W = $clog2(MAX_COLS+1);
  localparam int RUN_W = CNT_W + PIX_W;
  localparam int ACC_W = CNT_W + 1;
  localparam int CMP_W = (ACC_W > IDX_W) ? ACC_W : IDX_W;
  localparam int RCW   = (RD_W > IDX_W + 1) ? RD_W : IDX_W + 1;

  typedef enum logic [3:0] {
    W_IDLE  = 4'b0001,
    W_FIRST = 4'b0010,
    W_END   = 4'b0100,
    W_RUN   = 4'b1000
  } walk_state_t;

  walk_state_t      state, state_next;
  logic [IDX_W-1:0] row_q, row_q_next;
  logic [IDX_W-1:0] col_q, col_q_next;
  logic [RN_W-1:0]  ptr, ptr_next;
  logic [RN_W-1:0]  end_idx, end_idx_next;
  logic [ACC_W-1:0] acc, acc_next, acc_sum;
  logic [ACC_W-1:0] n, n_next, n_inc;
  logic             pend, pend_next;
  logic [RCW-1:0]   row_inc;
  logic             hit;

  assign acc_sum = acc + ACC_W'(rs_rdata[RUN_W-1:PIX_W]);
  assign hit     = CMP_W'(acc_sum) > CMP_W'(col_q);
  assign n_inc   = n + 1'b1;
  assign row_inc = RCW'(row_q) + 1'b1;

  always_comb begin
    state_next   = state;
    row_q_next   = row_q;
    col_q_next   = col_q;
    ptr_next     = ptr;
    end_idx_next = end_idx;
    acc_next     = acc;
    n_next       = n;
    pend_next    = pend;
    rfr_re       = 1'b0;
    rfr_raddr    = RA_W'(row_q);
    rs_re        = 1'b0;
    rs_raddr     = RS_AW'(ptr);
    rsp          = '0;
    case (state)
      W_IDLE: begin
        if (req.start) begin
          rfr_re     = 1'b1;
          rfr_raddr  = RA_W'(req.row);
          row_q_next = req.row;
          col_q_next = req.col;
          state_next = W_FIRST;
        end
      end
      W_FIRST: begin
        ptr_next  = rfr_rdata;
        acc_next  = '0;
        n_next    = '0;
        pend_next = 1'b0;
        // end of this row is the next row's first run, else the open row's, else the count
        if (row_inc < RCW'(rows_done)) begin
          rfr_re     = 1'b1;
          rfr_raddr  = RA_W'(row_inc);
          state_next = W_END;
        end else if (row_open) begin
          rfr_re     = 1'b1;
          rfr_raddr  = RA_W'(rows_done);
          state_next = W_END;
        end else begin
          end_idx_next = runs_done;
          state_next   = W_RUN;
        end
      end
      W_END: begin
        end_idx_next = (rfr_rdata > runs_done) ? runs_done : rfr_rdata;
        state_next   = W_RUN;
      end
      W_RUN: begin
        if (pend) begin
          acc_next = acc_sum;
          n_next   = n_inc;
        end
        if (pend && hit) begin
          rsp.done    = 1'b1;
          rsp.hit     = 1'b1;
          rsp.value   = rs_rdata[PIX_W-1:0];
          rsp.visited = VIS_W'(n_inc);
          pend_next   = 1'b0;
          state_next  = W_IDLE;
        end else if (ptr >= end_idx) begin
          // drain the last read; miss once nothing is in flight
          pend_next = 1'b0;
          if (!pend) begin
            rsp.done   = 1'b1;
            state_next = W_IDLE;
          end
        end else begin
          rs_re     = 1'b1;
          ptr_next  = ptr + 1'b1;
          pend_next = 1'b1;
        end
      end
      default: state_next = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    row_q   <= row_q_next;
    col_q   <= col_q_next;
    ptr     <= ptr_next;
    end_idx <= end_idx_next;
    acc     <= acc_next;
    n       <= n_next;
  end

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == W_RUN) |-> (ptr <= end_idx))
    else $error("walk pointer passed end of row");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (state == W_IDLE))
    else $error("lookup started while walk busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> (state == W_IDLE))
    else $error("walk did not return to idle after done");

endmodule

// File: hw/rtl/rle_frame_store_with_lookup.sv
// Channel   Dir  Handshake        Payload
// cmd_ch    in   valid / ready    command, pixel_value, lookup_row, lookup_col
// res_ch    out  valid / ready    status, read_value, runs_visited, total_runs
// cfg       in   cfg_wr_en        cfg_wr_data (frame_cols)
//
// Clear, unused command and push answer directly; a push that ends a run and closes
// its row on the same pixel makes two writes to the run store port. A lookup reads
// its row's first run, then its end unless it is the last closed row and none is open,
// then walks runs (one run store read port); an out-of-range row answers directly.
// Synchronous reset clears counters and open run; both stores stay undefined.
// A new item is taken while a result waits only if that result leaves in the same cycle.
module rle_frame_store_with_lookup import rlefs_pkg::*; #(
  parameter int MAX_RUNS = 65536,
  parameter int MAX_ROWS = 4096,
  parameter int MAX_COLS = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [FC_W-1:0] cfg_wr_data,
  rlefs_cmd_if.sink       cmd_ch,
  rlefs_res_if.source     res_ch
);

  localparam int CNT_W = $clog2(MAX_COLS+1);
  localparam int CC_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RD_W  = $clog2(MAX_ROWS+1);
  localparam int RA_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RN_W  = $clog2(MAX_RUNS+1);
  localparam int RS_AW = $clog2(MAX_RUNS);
  localparam int RUN_W = CNT_W + PIX_W;
  localparam int RCW   = (RD_W > IDX_W) ? RD_W : IDX_W;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_WR2  = 3'b010,
    T_LOOK = 3'b100
  } top_state_t;

  top_state_t       state;
  logic [FC_W-1:0]  frame_cols;
  logic [CNT_W-1:0] orl, orl_next;
  logic [PIX_W-1:0] orv, orv_next;
  logic [CC_W-1:0]  cc;
  logic [RD_W-1:0]  rows_done;
  logic [RN_W-1:0]  runs_done, runs_done_next;

  logic [CNT_W-1:0] cols;
  logic             accept;
  logic             starts, differs, closes;
  logic [1:0]       need;
  logic             push_ok, push_go, row_ok;
  logic [CNT_W-1:0] len_close;

  logic             res_valid, res_load;
  logic [STS_W-1:0] res_status, res_status_next;
  logic [PIX_W-1:0] res_value, res_value_next;
  logic [VIS_W-1:0] res_visited, res_visited_next;
  logic [TOT_W-1:0] res_total, res_total_next;

  logic [RS_AW-1:0] pend_addr;
  logic [PIX_W-1:0] pend_val;

  logic             rfr_we, rfr_re;
  logic [RA_W-1:0]  rfr_raddr;
  logic [RN_W-1:0]  rfr_rdata;
  logic             rs_we, rs_re;
  logic [RS_AW-1:0] rs_waddr, rs_raddr;
  logic [RUN_W-1:0] rs_wdata, rs_rdata;
  logic             lk_start;
  lk_req_t          lk_req;
  lk_rsp_t          lk_rsp;

  always_comb begin
    if (frame_cols == '0) begin
      cols = CNT_W'(1);
    end else if ((FC_W+1)'(frame_cols) > (FC_W+1)'(MAX_COLS)) begin
      cols = CNT_W'(MAX_COLS);
    end else begin
      cols = CNT_W'(frame_cols);
    end
  end

  assign cmd_ch.ready = (state == T_IDLE) && (!res_valid || res_ch.ready);
  assign accept       = cmd_ch.valid && cmd_ch.ready;

  assign starts    = (cc == '0);
  assign differs   = !starts && (cmd_ch.pixel_value != orv);
  assign closes    = (CNT_W'(cc) + 1'b1) >= cols;
  assign need      = {1'b0, differs} + {1'b0, closes};
  assign push_ok   = !(starts && (rows_done == RD_W'(MAX_ROWS))) &&
                     ((RN_W+1)'(runs_done) + (RN_W+1)'(need) <= (RN_W+1)'(MAX_RUNS));
  assign len_close = starts ? CNT_W'(1) : orl + 1'b1;
  assign runs_done_next = runs_done + RN_W'(need);
  assign row_ok    = RCW'(cmd_ch.lookup_row) < RCW'(rows_done);

  always_comb begin
    if (closes) begin
      orl_next = '0;
    end else if (starts || differs) begin
      orl_next = CNT_W'(1);
    end else begin
      orl_next = orl + 1'b1;
    end
    orv_next = (starts || differs) ? cmd_ch.pixel_value : orv;
  end

  always_comb begin
    res_load         = 1'b0;
    res_status_next  = STS_OK;
    res_value_next   = '0;
    res_visited_next = '0;
    res_total_next   = TOT_W'(runs_done);
    rfr_we           = 1'b0;
    rs_we            = 1'b0;
    rs_waddr         = RS_AW'(runs_done);
    rs_wdata         = {orl, orv};
    lk_start         = 1'b0;
    push_go          = 1'b0;
    case (state)
      T_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          case (cmd_ch.command)
            CMD_CLEAR: res_total_next = '0;
            CMD_PUSH: begin
              if (push_ok) begin
                push_go        = 1'b1;
                rfr_we         = starts;
                rs_we          = differs || closes;
                // a finished run goes out first; a closing run alone writes here
                if (!differs) begin
                  rs_wdata = {len_close, cmd_ch.pixel_value};
                end
                res_total_next = TOT_W'(runs_done_next);
              end else begin
                res_status_next = STS_FULL;
              end
            end
            CMD_LOOKUP: begin
              if (row_ok) begin
                res_load = 1'b0;
                lk_start = 1'b1;
              end else begin
                res_status_next = STS_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      T_WR2: begin
        rs_we    = 1'b1;
        rs_waddr = pend_addr;
        rs_wdata = {CNT_W'(1), pend_val};
      end
      T_LOOK: begin
        if (lk_rsp.done) begin
          res_load = 1'b1;
          if (lk_rsp.hit) begin
            res_value_next   = lk_rsp.value;
            res_visited_next = lk_rsp.visited;
          end else begin
            res_status_next = STS_RANGE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      res_valid  <= 1'b0;
      frame_cols <= FRAME_COLS_RESET;
      orl        <= '0;
      orv        <= '0;
      cc         <= '0;
      rows_done  <= '0;
      runs_done  <= '0;
    end else begin
      if (cfg_wr_en) begin
        frame_cols <= cfg_wr_data;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ch.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept && cmd_ch.command == CMD_CLEAR) begin
            orl       <= '0;
            orv       <= '0;
            cc        <= '0;
            rows_done <= '0;
            runs_done <= '0;
          end
          if (push_go) begin
            orl       <= orl_next;
            orv       <= orv_next;
            cc        <= closes ? '0 : cc + 1'b1;
            rows_done <= rows_done + RD_W'(closes);
            runs_done <= runs_done_next;
            if (differs && closes) begin
              state <= T_WR2;
            end
          end
          if (lk_start) begin
            state <= T_LOOK;
          end
        end
        T_WR2: state <= T_IDLE;
        T_LOOK: begin
          if (lk_rsp.done) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status  <= res_status_next;
      res_value   <= res_value_next;
      res_visited <= res_visited_next;
      res_total   <= res_total_next;
    end
    // hold the new one-pixel run for the second write
    if (push_go) begin
      pend_addr <= RS_AW'(runs_done + 1'b1);
      pend_val  <= cmd_ch.pixel_value;
    end
  end

  assign res_ch.valid        = res_valid;
  assign res_ch.status       = res_status;
  assign res_ch.read_value   = res_value;
  assign res_ch.runs_visited = res_visited;
  assign res_ch.total_runs   = res_total;

  assign lk_req = '{start: lk_start, row: cmd_ch.lookup_row, col: cmd_ch.lookup_col};

  rlefs_ram #(
    .WIDTH (RN_W),
    .DEPTH (MAX_ROWS)
  ) u_row_first (
    .clk   (clk),
    .we    (rfr_we),
    .waddr (RA_W'(rows_done)),
    .wdata (runs_done),
    .re    (rfr_re),
    .raddr (rfr_raddr),
    .rdata (rfr_rdata)
  );

  rlefs_ram #(
    .WIDTH (RUN_W),
    .DEPTH (MAX_RUNS)
  ) u_run_store (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rs_wdata),
    .re    (rs_re),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  rlefs_walk #(
    .MAX_RUNS (MAX_RUNS),
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .req       (lk_req),
    .rows_done (rows_done),
    .row_open  (cc != '0),
    .runs_done (runs_done),
    .rfr_re    (rfr_re),
    .rfr_raddr (rfr_raddr),
    .rfr_rdata (rfr_rdata),
    .rs_re     (rs_re),
    .rs_raddr  (rs_raddr),
    .rs_rdata  (rs_rdata),
    .rsp       (lk_rsp)
  );

  a_open_run: assert property (@(posedge clk) disable iff (rst)
    (cc == '0) == (orl == '0))
    else $error("open run length out of step with column counter");

  a_runs_cap: assert property (@(posedge clk) disable iff (rst)
    runs_done <= RN_W'(MAX_RUNS))
    else $error("run count beyond store depth");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != T_IDLE) |-> !cmd_ch.ready)
    else $error("item taken while a write or lookup is pending");

endmodule
